// File: sv/set_assoc_cache_tag_controller_core_assert.svh
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_CORE_ASSERT_SVH

// check an implication on every clock edge outside reset
`define STC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check an implication in the next cycle
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/stc_pkg.sv
`default_nettype none
package stc_pkg;
	localparam int SETS       = 16;
	localparam int WAYS_N     = 4;
	localparam int LINE_BYTES = 64;
	localparam int NLINES     = SETS * WAYS_N;
	localparam int OFF_W      = $clog2(LINE_BYTES);
	localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W      = (WAYS_N > 1) ? $clog2(WAYS_N) : 1;
	localparam int LIDX_W     = (NLINES > 1) ? $clog2(NLINES) : 1;
	localparam int TAG_W      = 64;
	localparam int ENT_W      = TAG_W + 32;

	localparam logic [2:0] FN_READ      = 3'd0;
	localparam logic [2:0] FN_WRITE     = 3'd1;
	localparam logic [2:0] FN_ZERO      = 3'd2;
	localparam logic [2:0] FN_FLUSH     = 3'd3;
	localparam logic [2:0] FN_CLEAR     = 3'd4;
	localparam logic [2:0] FN_FLUSH_ALL = 3'd5;
	localparam logic [2:0] FN_CLEAR_ALL = 3'd6;
	localparam logic [2:0] FN_NONE      = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] req_addr_hi;
		logic [31:0] req_addr_lo;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  set_index;
		logic [1:0]  way_index;
		logic [5:0]  byte_offset;
		logic        writeback;
		logic [31:0] victim_hi;
		logic [31:0] victim_lo;
		logic        fill;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [2:0]       func;
		logic [31:0]      hi;
		logic [31:0]      start;
		logic [SET_W-1:0] set;
		logic [5:0]       off;
	} work_t;

	function automatic logic [LIDX_W-1:0] lidx(input logic [SET_W-1:0] s,
		input logic [WAY_W-1:0] w);
		lidx = LIDX_W'(int'(s) * WAYS_N + int'(w));
	endfunction
endpackage
`default_nettype wire

// File: sv/stc_ram.sv
`default_nettype none
module stc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                     wdata,
	input  wire logic                             re,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic      [W-1:0]                     rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: sv/stc_front.sv
`default_nettype none
module stc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire stc_pkg::req_t in_data,
	output logic               q_valid,
	output stc_pkg::work_t     q_item,
	input  wire logic          q_pop
);
	import stc_pkg::*;

	work_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	work_t      dec;
	logic       push;

	always_comb begin
		dec.func  = in_data.func;
		dec.hi    = in_data.req_addr_hi;
		dec.start = in_data.req_addr_lo & ~32'(LINE_BYTES - 1);
		dec.set   = SET_W'((in_data.req_addr_lo >> OFF_W) % SETS);
		dec.off   = 6'(in_data.req_addr_lo & 32'(LINE_BYTES - 1));
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

// File: sv/stc_back.sv
`default_nettype none
`include "set_assoc_cache_tag_controller_core_assert.svh"
module stc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire stc_pkg::work_t q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output stc_pkg::rsp_t       out_data
);
	import stc_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOOK   = 3'd1;
	localparam logic [2:0] S_DEC    = 3'd2;
	localparam logic [2:0] S_FA_RD  = 3'd3;
	localparam logic [2:0] S_FA_WAY = 3'd4;
	localparam logic [2:0] S_ZERO   = 3'd5;

	logic [2:0]        st_q;
	work_t             wk_q;
	logic [31:0]       cnt_q;
	logic [NLINES-1:0] vld_q;
	logic [NLINES-1:0] drt_q;
	logic              hit_s2;
	logic [WAY_W-1:0]  hway_s2;
	logic [31:0]       age_s2 [WAYS_N];
	logic [SET_W-1:0]  fa_set_q;
	logic [WAY_W-1:0]  fa_way_q;
	rsp_t              out_q;
	logic              out_v_q;

	logic [ENT_W-1:0]  rd [WAYS_N];
	logic              re;
	logic [SET_W-1:0]  raddr;
	logic [WAYS_N-1:0] we;
	logic [ENT_W-1:0]  wdata;

	logic              slot_free;
	logic              out_load;
	rsp_t              res;
	logic              look_hit;
	logic [WAY_W-1:0]  look_way;
	logic [WAY_W-1:0]  vict;
	logic [WAY_W-1:0]  uway;
	logic [LIDX_W-1:0] li;
	logic [LIDX_W-1:0] fa_li;
	logic [NLINES-1:0] later;
	logic [31:0]       inc;

	assign slot_free = !out_v_q || out_ready;
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign q_pop     = (st_q == S_IDLE) && q_valid;
	assign re        = (q_pop && (q_item.func <= FN_CLEAR)) || (st_q == S_FA_RD);
	assign raddr     = (st_q == S_FA_RD) ? fa_set_q : q_item.set;

	for (genvar g = 0; g < WAYS_N; g++) begin : g_way
		stc_ram #(.W(ENT_W), .D(SETS)) u_ram (
			.clk   (clk),
			.we    (we[g]),
			.waddr (wk_q.set),
			.wdata (wdata),
			.re    (re),
			.raddr (raddr),
			.rdata (rd[g])
		);
	end

	always_comb begin
		logic [LIDX_W-1:0] k;
		look_hit = 1'b0;
		look_way = '0;
		for (int w = WAYS_N - 1; w >= 0; w--) begin
			k = lidx(wk_q.set, WAY_W'(w));
			if (vld_q[k] && rd[w][ENT_W-1:32] == {wk_q.hi, wk_q.start}) begin
				look_hit = 1'b1;
				look_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		logic [31:0] best;
		logic        done;
		logic [LIDX_W-1:0] k;
		best = age_s2[0];
		done = 1'b0;
		vict = '0;
		for (int w = 0; w < WAYS_N; w++) begin
			k = lidx(wk_q.set, WAY_W'(w));
			if (!done) begin
				if (!vld_q[k]) begin
					vict = WAY_W'(w);
					done = 1'b1;
				end else if (age_s2[w] >= best) begin
					best = age_s2[w];
					vict = WAY_W'(w);
				end
			end
		end
	end

	assign uway  = hit_s2 ? hway_s2 : vict;
	assign li    = lidx(wk_q.set, uway);
	assign fa_li = lidx(fa_set_q, fa_way_q);
	assign inc   = (hit_s2 && wk_q.func == FN_ZERO) ? 32'd2 : 32'd1;
	assign wdata = {wk_q.hi, wk_q.start, cnt_q + inc};

	always_comb begin
		for (int i = 0; i < NLINES; i++) begin
			later[i] = (LIDX_W'(i) > fa_li);
		end
	end

	always_comb begin
		res      = '0;
		res.last = 1'b1;
		we       = '0;
		out_load = 1'b0;
		unique case (st_q)
			S_DEC: begin
				out_load        = slot_free;
				res.set_index   = 4'(wk_q.set);
				res.byte_offset = wk_q.off;
				res.hit         = hit_s2;
				if (wk_q.func <= FN_ZERO) begin
					res.way_index = 2'(uway);
					res.writeback = !hit_s2 && vld_q[li] && drt_q[li];
					res.fill      = !hit_s2 && (wk_q.func != FN_ZERO);
					we[uway]      = slot_free;
				end else if (hit_s2) begin
					res.way_index = 2'(uway);
					res.writeback = (wk_q.func == FN_FLUSH) && drt_q[li];
					we[uway]      = slot_free;
				end
				if (res.writeback) begin
					{res.victim_hi, res.victim_lo} = rd[uway][ENT_W-1:32];
				end
			end
			S_FA_WAY: begin
				out_load      = slot_free && vld_q[fa_li] && drt_q[fa_li];
				res.set_index = 4'(fa_set_q);
				res.way_index = 2'(fa_way_q);
				res.writeback = 1'b1;
				{res.victim_hi, res.victim_lo} = rd[fa_way_q][ENT_W-1:32];
				res.last      = ~|(vld_q & drt_q & later);
			end
			S_ZERO: begin
				out_load = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			wk_q <= q_item;
		end
		if (out_load) begin
			out_q <= res;
		end
		if (st_q == S_LOOK) begin
			hit_s2  <= look_hit;
			hway_s2 <= look_way;
			for (int w = 0; w < WAYS_N; w++) begin
				age_s2[w] <= cnt_q - rd[w][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			cnt_q    <= '0;
			vld_q    <= '0;
			drt_q    <= '0;
			fa_set_q <= '0;
			fa_way_q <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						priority if (q_item.func <= FN_CLEAR) begin
							st_q <= S_LOOK;
						end else if (q_item.func == FN_FLUSH_ALL) begin
							fa_set_q <= '0;
							fa_way_q <= '0;
							st_q     <= (|(vld_q & drt_q)) ? S_FA_RD : S_ZERO;
						end else if (q_item.func == FN_CLEAR_ALL) begin
							vld_q <= '0;
							drt_q <= '0;
							cnt_q <= '0;
							st_q  <= S_ZERO;
						end else begin
							st_q <= S_ZERO;
						end
					end
				end
				S_LOOK: begin
					st_q <= S_DEC;
				end
				S_DEC: begin
					if (slot_free) begin
						st_q <= S_IDLE;
						if (wk_q.func <= FN_ZERO) begin
							cnt_q     <= cnt_q + inc;
							vld_q[li] <= 1'b1;
							drt_q[li] <= (wk_q.func != FN_READ) || (hit_s2 && drt_q[li]);
						end else if (hit_s2) begin
							cnt_q     <= cnt_q + 32'd1;
							drt_q[li] <= 1'b0;
							if (wk_q.func == FN_CLEAR) begin
								vld_q[li] <= 1'b0;
							end
						end
					end
				end
				S_FA_RD: begin
					st_q <= S_FA_WAY;
				end
				S_FA_WAY: begin
					if (vld_q[fa_li] && drt_q[fa_li]) begin
						if (slot_free) begin
							drt_q[fa_li] <= 1'b0;
							if (res.last) begin
								st_q <= S_IDLE;
							end else if (fa_way_q == WAY_W'(WAYS_N - 1)) begin
								fa_way_q <= '0;
								fa_set_q <= fa_set_q + 1'b1;
								st_q     <= S_FA_RD;
							end else begin
								fa_way_q <= fa_way_q + 1'b1;
							end
						end
					end else if (fa_way_q == WAY_W'(WAYS_N - 1)) begin
						fa_way_q <= '0;
						fa_set_q <= fa_set_q + 1'b1;
						st_q     <= S_FA_RD;
					end else begin
						fa_way_q <= fa_way_q + 1'b1;
					end
				end
				S_ZERO: begin
					if (slot_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	`STC_ASSERT_IMP(a_tag_write_in_dec, |we, st_q == S_DEC && slot_free, "tag write outside decide")
	`STC_ASSERT_IMP(a_load_needs_slot, out_load, slot_free, "result overwrites a waiting one")
	`STC_ASSERT_NEXT(a_look_follows_pop, q_pop && q_item.func <= FN_CLEAR, st_q == S_LOOK, "lookup skipped")
	`STC_ASSERT_IMP(a_fa_only_dirty, out_load && st_q == S_FA_WAY, vld_q[fa_li] && drt_q[fa_li], "clean line flushed")
endmodule
`default_nettype wire

// File: sv/set_assoc_cache_tag_controller_core.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_data   (stc_pkg::req_t)
// out      output     out_valid / out_ready out_data  (stc_pkg::rsp_t)
//
// Line requests pass through queue pop, tag RAM read and compare, then victim choice and write.
// Flush all reads each set walked, then checks its ways in turn, up to the last dirty line.
// With no dirty line, flush all, clear all and the unused code go from the pop to an empty reply.
// A two-item queue takes new items while the back end works or waits on out_ready.
// Reset clears valid and dirty bits and the access counter at once; tag RAM needs no pass.
`default_nettype none
module set_assoc_cache_tag_controller_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire stc_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output stc_pkg::rsp_t      out_data
);
	import stc_pkg::*;

	logic  q_valid;
	logic  q_pop;
	work_t q_item;

	stc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	stc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);
endmodule
`default_nettype wire
